FILE: rtl/ddo_pkg.sv
`default_nettype none
package ddo_pkg;

  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned CntPortW  = 32;
  localparam int unsigned CmW       = 16;
  localparam int unsigned ApcW      = 24;
  localparam int unsigned PosW      = 32;
  localparam int unsigned HeadW     = 16;
  localparam int unsigned TravW     = 40;
  localparam int unsigned MulAW     = 41;
  localparam int unsigned MulBW     = 26;
  localparam int unsigned MulPW     = MulAW + MulBW;
  localparam int unsigned SumW      = 46;
  localparam int unsigned CordW     = 34;
  localparam int unsigned TrigW     = 26;
  localparam int unsigned StepW     = 5;
  localparam int unsigned AngW      = 32;

  localparam int unsigned DefCordicSteps = 16;
  localparam int unsigned DefCountBits   = 32;

  localparam logic [CfgIdxW-1:0] REG_CM_PER_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_PER_CM = 1'b1;

  localparam logic [CmW-1:0]  CM_RESET  = 16'd655;
  localparam logic [ApcW-1:0] APC_RESET = 24'd267008;

  localparam logic signed [CordW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [HeadW-1:0] QUARTER_POS = 16'sd16384;
  localparam logic signed [HeadW-1:0] QUARTER_NEG = -16'sd16384;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  function automatic logic [AngW-1:0] atan_lookup(input logic [StepW-1:0] idx);
    logic [AngW-1:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    logic signed [PosW-1:0] r;
    hi = SumW'(signed'({1'b0, {(PosW-1){1'b1}}}));
    lo = -hi - SumW'(1);
    if (v > hi) r = {1'b0, {(PosW-1){1'b1}}};
    else if (v < lo) r = {1'b1, {(PosW-1){1'b0}}};
    else r = v[PosW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ddo_mul.sv
`default_nettype none
module ddo_mul (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [ddo_pkg::MulAW-1:0]    a_i,
  input  wire logic signed [ddo_pkg::MulBW-1:0]    b_i,
  output logic signed [ddo_pkg::MulPW-1:0]         p_o
);
  import ddo_pkg::*;

  logic signed [MulPW-1:0] p_q;

  // hold the product until the next operand pair is issued
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MulPW'(a_i) * MulPW'(b_i);
    end
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

FILE: rtl/ddo_cordic.sv
`default_nettype none
module ddo_cordic #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::DefCordicSteps
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [ddo_pkg::HeadW-1:0]         heading_i,
  output ddo_pkg::cordic_stat_t                  stat_o,
  output logic signed [ddo_pkg::TrigW-1:0]       cos_o,
  output logic signed [ddo_pkg::TrigW-1:0]       sin_o
);
  import ddo_pkg::*;

  logic                    busy_q, done_q, flip_q;
  logic [StepW-1:0]        cnt_q;
  logic signed [CordW-1:0] x_q, y_q, z_q;
  logic signed [CordW-1:0] xs, ys, at, xo, yo;
  logic signed [HeadW-1:0] hs;
  logic [AngW-1:0]         z0;
  logic                    flip0;

  assign hs    = signed'(heading_i);
  assign flip0 = (hs > QUARTER_POS) || (hs < QUARTER_NEG);
  // a half turn on the binary angle is just the top bit
  assign z0    = {heading_i[HeadW-1] ^ flip0, heading_i[HeadW-2:0], {(AngW-HeadW){1'b0}}};

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = CordW'(atan_lookup(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        flip_q <= flip0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == StepW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + StepW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_GAIN;
      y_q <= '0;
      z_q <= CordW'(signed'(z0));
    end else if (busy_q) begin
      if (!z_q[CordW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign xo = flip_q ? -x_q : x_q;
  assign yo = flip_q ? -y_q : y_q;
  assign cos_o = xo[CordW-1:CordW-TrigW];
  assign sin_o = yo[CordW-1:CordW-TrigW];

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("cordic done while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q)) else $error("cordic done without run");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("cordic failed to start");
endmodule
`default_nettype wire

FILE: rtl/differential_drive_odometry_top.sv
// An accepted update runs through S_ML, S_MR, S_MD, S_WAIT (until the CORDIC is done),
//   S_MC, S_FIN and S_PUB to a valid pose; a restart goes from S_IDLE straight to S_PUB.
// A new update or restart is taken only in S_IDLE, after the last one is published; the
//   iterative CORDIC and the single shared multiplier set the update rate.
// Reset clears pose, encoder baseline and handshakes and reloads both config
//   registers with their defaults.
`default_nettype none
module differential_drive_odometry_top #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::DefCordicSteps,
  parameter int unsigned COUNT_BITS   = ddo_pkg::DefCountBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ddo_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [ddo_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             kind_i,
  input  wire logic [ddo_pkg::CntPortW-1:0]     left_count_i,
  input  wire logic [ddo_pkg::CntPortW-1:0]     right_count_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [ddo_pkg::PosW-1:0]       x_pos_o,
  output logic signed [ddo_pkg::PosW-1:0]       y_pos_o,
  output logic signed [ddo_pkg::HeadW-1:0]      heading_o
);
  import ddo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ML, S_MR, S_MD, S_WAIT, S_MC, S_FIN, S_PUB
  } state_e;

  state_e                  state_q;
  logic [CmW-1:0]          cm_q;
  logic [ApcW-1:0]         apc_q;
  logic [COUNT_BITS-1:0]   prev_l_q, prev_r_q, dl_q, dr_q;
  logic signed [TravW-1:0] tl_q, dist_q;
  logic signed [PosW-1:0]  pose_x_q, pose_y_q;
  logic [HeadW-1:0]        pose_h_q;
  logic                    out_valid_q;
  logic signed [PosW-1:0]  x_out_q, y_out_q;
  logic [HeadW-1:0]        h_out_q;

  logic                    accept, start_cordic, mul_en;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;
  logic signed [TravW-1:0] trav, tr_w;
  logic signed [MulAW-1:0] tsum, tdiff;
  logic signed [SumW-1:0]  step_ext;
  logic signed [TrigW-1:0] cos_w, sin_w;
  cordic_stat_t            cstat;
  logic [COUNT_BITS-1:0]   l_w, r_w;

  assign accept       = in_valid_i && in_ready_o;
  assign start_cordic = accept && !kind_i;
  assign l_w          = left_count_i[COUNT_BITS-1:0];
  assign r_w          = right_count_i[COUNT_BITS-1:0];

  assign trav  = prod[TravW+7:8];
  assign tr_w  = trav;
  assign tsum  = MulAW'(tl_q) + MulAW'(tr_w);
  assign tdiff = MulAW'(tl_q) - MulAW'(tr_w);
  assign step_ext = SumW'(signed'(prod[MulPW-1:22]));

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_ML: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(signed'(dl_q));
        mul_b  = MulBW'(signed'({1'b0, cm_q}));
      end
      S_MR: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(signed'(dr_q));
        mul_b  = MulBW'(signed'({1'b0, cm_q}));
      end
      S_MD: begin
        mul_en = 1'b1;
        mul_a  = tdiff;
        mul_b  = MulBW'(signed'({1'b0, apc_q}));
      end
      S_WAIT: begin
        mul_en = !cstat.busy;
        mul_a  = MulAW'(dist_q);
        mul_b  = sin_w;
      end
      S_MC: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(dist_q);
        mul_b  = cos_w;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  ddo_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_cordic),
    .heading_i (pose_h_q),
    .stat_o    (cstat),
    .cos_o     (cos_w),
    .sin_o     (sin_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cm_q        <= CM_RESET;
      apc_q       <= APC_RESET;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_h_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CM_PER_COUNT) cm_q <= cfg_wdata_i[CmW-1:0];
        if (cfg_idx_i == REG_ANGLE_PER_CM) apc_q <= cfg_wdata_i[ApcW-1:0];
      end
      if (out_valid_q && out_ready_i && state_q != S_PUB) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            prev_l_q <= l_w;
            prev_r_q <= r_w;
            if (kind_i) begin
              pose_x_q <= '0;
              pose_y_q <= '0;
              pose_h_q <= '0;
              state_q  <= S_PUB;
            end else begin
              state_q <= S_ML;
            end
          end
        end
        S_ML:  state_q <= S_MR;
        S_MR:  state_q <= S_MD;
        S_MD:  state_q <= S_WAIT;
        S_WAIT: begin
          // heading product waits in the multiplier until the CORDIC is through
          if (!cstat.busy) begin
            pose_h_q <= pose_h_q + prod[31:16];
            state_q  <= S_MC;
          end
        end
        S_MC: begin
          pose_x_q <= sat_pos(SumW'(pose_x_q) + step_ext);
          state_q  <= S_FIN;
        end
        S_FIN: begin
          pose_y_q <= sat_pos(SumW'(pose_y_q) + step_ext);
          state_q  <= S_PUB;
        end
        S_PUB: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dl_q <= l_w - prev_l_q;
      dr_q <= r_w - prev_r_q;
    end
    if (state_q == S_MR) tl_q <= trav;
    if (state_q == S_MD) dist_q <= tsum[TravW:1];
    if (state_q == S_PUB && (!out_valid_q || out_ready_i)) begin
      x_out_q <= pose_x_q;
      y_out_q <= pose_y_q;
      h_out_q <= pose_h_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign x_pos_o     = x_out_q;
  assign y_pos_o     = y_out_q;
  assign heading_o   = signed'(h_out_q);

  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i |=> pose_x_q == '0 && pose_y_q == '0 && pose_h_q == '0)
    else $error("restart did not clear pose");
  a_idle_cordic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cstat.busy) else $error("ready while cordic runs");
  a_pub_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUB && (!out_valid_q || out_ready_i) |=> out_valid_q)
    else $error("result not published");
endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] left;
    logic [31:0] right;
  } enc_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] head;
  } pose_t;

  localparam longint AtanQ32 [0:15] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = REG_CM_PER_COUNT;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic kind_i = 1'b0;
  logic [31:0] left_count_i = '0;
  logic [31:0] right_count_i = '0;
  logic out_ready_i = 1'b1;
  logic in_ready_o, out_valid_o;
  logic signed [31:0] x_pos_o, y_pos_o;
  logic signed [15:0] heading_o;

  differential_drive_odometry_top dut (.*);

  always #1 clk_i = ~clk_i;

  enc_item_t pending_q[$];
  pose_t     pose_q[$];
  int        errors = 0;
  bit        quiet = 1'b0;
  bit        took_in = 1'b0;
  int        send_gap = 0;
  int        recv_gap = 0;

  // predictor state
  longint       odo_x = 0, odo_y = 0;
  logic [15:0]  odo_head = '0;
  logic [31:0]  base_l = '0, base_r = '0;
  logic [15:0]  cm_reg = CM_RESET;
  logic [23:0]  apc_reg = APC_RESET;
  logic [31:0]  gen_l = '0, gen_r = '0;

  function automatic void trig_q30(input logic [15:0] h, output longint c, output longint s);
    longint hs, z, x, y, xs, ys;
    bit flip;
    hs = longint'($signed(h));
    z = hs * 65536;
    x = 652032874;
    y = 0;
    flip = 0;
    if (hs > 16384) begin
      z -= 64'sd1 << 31;
      flip = 1;
    end else if (hs < -16384) begin
      z += 64'sd1 << 31;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= AtanQ32[i];
      end else begin
        x += ys; y -= xs; z += AtanQ32[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pose_t advance_pose(input enc_item_t it);
    longint tl, tr, mean_trav, c, s;
    longint unsigned p;
    pose_t r;
    if (it.kind) begin
      odo_x = 0; odo_y = 0; odo_head = '0;
    end else begin
      tl = (longint'($signed(it.left - base_l)) * longint'(cm_reg)) >>> 8;
      tr = (longint'($signed(it.right - base_r)) * longint'(cm_reg)) >>> 8;
      mean_trav = (tl + tr) >>> 1;
      trig_q30(odo_head, c, s);
      c = c >>> 8;
      s = s >>> 8;
      odo_y = clamp32(odo_y + ((mean_trav * c) >>> 22));
      odo_x = clamp32(odo_x + ((mean_trav * s) >>> 22));
      p = longint'(tl - tr) * longint'(apc_reg);
      odo_head = odo_head + p[31:16];
    end
    base_l = it.left;
    base_r = it.right;
    r.x = odo_x[31:0];
    r.y = odo_y[31:0];
    r.head = odo_head;
    return r;
  endfunction

  // sender: hold payload until the transaction completes
  always @(negedge clk_i) begin
    logic v;
    enc_item_t it;
    v = in_valid_i;
    it = '{kind_i, left_count_i, right_count_i};
    if (!in_valid_i || took_in) begin
      v = 1'b0;
      if (send_gap > 0) send_gap--;
      else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        v = 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 3);
      end
    end
    in_valid_i <= v;
    kind_i <= it.kind;
    left_count_i <= it.left;
    right_count_i <= it.right;
    if (recv_gap > 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    pose_t exp_p;
    took_in <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o)
      pose_q.insert(pose_q.size(), advance_pose('{kind_i, left_count_i, right_count_i}));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pose_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pose x=%0d y=%0d h=%0d",
                                   x_pos_o, y_pos_o, heading_o);
      end else begin
        exp_p = pose_q.pop_front();
        if (exp_p.x !== x_pos_o || exp_p.y !== y_pos_o || exp_p.head !== heading_o) begin
          errors++;
          if (errors <= 10)
            $display("pose mismatch: exp x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                     exp_p.x, exp_p.y, exp_p.head, x_pos_o, y_pos_o, heading_o);
        end
      end
    end
  end

  task automatic add_item(input logic kind, input logic [31:0] l, input logic [31:0] r);
    enc_item_t it;
    it = '{kind, l, r};
    pending_q.insert(pending_q.size(), it);
    gen_l = l;
    gen_r = r;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || pose_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    if (idx == REG_CM_PER_COUNT) cm_reg = val[15:0];
    else apc_reg = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_items(input int n);
    logic [31:0] dl, dr;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0:       add_item(1'b1, $urandom, $urandom);
        1, 2:    add_item(1'b0, $urandom, $urandom);
        3:       add_item(1'($urandom_range(0, 1)), gen_l, gen_r);
        default: begin
          dl = $urandom_range(0, 4000) - 2000;
          dr = ($urandom_range(0, 3) == 0) ? -dl : dl + $urandom_range(0, 400) - 200;
          add_item(1'b0, gen_l + dl, gen_r + dr);
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: baselines, zero travel, extremes, wrap, half-range change
    add_item(1'b0, 32'd0, 32'd0);
    add_item(1'b0, 32'd1000, 32'd1000);
    add_item(1'b0, 32'd2000, 32'd1500);
    add_item(1'b0, 32'd2000, 32'd1500);
    add_item(1'b1, 32'hFFFF_FFF0, 32'hFFFF_FF00);
    add_item(1'b0, 32'h0000_0010, 32'h0000_0100);
    add_item(1'b0, 32'h8000_0010, 32'h8000_0100);
    add_item(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    add_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    add_item(1'b0, 32'h0000_3000, 32'h0000_0000);
    add_item(1'b0, 32'h0000_6000, 32'h0000_0000);
    add_item(1'b0, 32'h0000_6000, 32'h0000_5000);
    add_item(1'b1, 32'd0, 32'd0);
    drain();

    write_reg(REG_CM_PER_COUNT, 24'hFFFF);
    write_reg(REG_ANGLE_PER_CM, 24'hFFFFFF);
    add_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    add_item(1'b0, 32'h7FFF_FFFD, 32'h7FFF_FFFD);
    add_item(1'b0, 32'h0000_0000, 32'h8000_0000);
    add_item(1'b0, 32'h8000_0000, 32'h0000_0000);
    random_items(180);
    drain();

    write_reg(REG_CM_PER_COUNT, 24'd0);
    write_reg(REG_ANGLE_PER_CM, 24'd0);
    random_items(150);
    drain();

    write_reg(REG_CM_PER_COUNT, 24'(CM_RESET));
    write_reg(REG_ANGLE_PER_CM, APC_RESET);
    random_items(250);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_CM_PER_COUNT, 24'($urandom_range(0, 65535)));
      write_reg(REG_ANGLE_PER_CM, 24'($urandom_range(0, 24'hFFFFFF)));
      random_items(200);
      drain();
    end

    // final stretch without idling
    quiet = 1'b1;
    write_reg(REG_CM_PER_COUNT, 24'($urandom_range(300, 3000)));
    write_reg(REG_ANGLE_PER_CM, 24'($urandom_range(100000, 2000000)));
    random_items(150);
    drain();

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
